FILE: rtl/igdd_pkg.sv
// Shared types and constants for the int4 group dequant dot-product block.
`timescale 1ns / 1ps
package igdd_pkg;

  // Longest row or group the counters handle.
  localparam int K_MAX = 4096;
  localparam int POS_W = $clog2(K_MAX);
  localparam int LEN_W = POS_W + 1;

  // Field widths fixed by the interface.
  localparam int ACT_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 16;
  localparam int CODE_W  = 4;
  localparam int PROD_W  = ACT_W + CODE_W;
  localparam int PART_W  = 32;
  localparam int SUM_W   = 48;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register reset values.
  localparam logic             SCALE_MODE_RST = 1'b1;
  localparam logic [CFG_W-1:0] ROW_LEN_RST    = 13'd4096;
  localparam logic [CFG_W-1:0] GRP_LEN_RST    = 13'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MODE = 2'd0,
    REG_ROW_LENGTH = 2'd1,
    REG_GRP_LEN    = 2'd2
  } igdd_reg_e;

  // One classified element as it travels from front to back.
  typedef struct packed {
    logic signed [ACT_W-1:0]   act;
    logic signed [CODE_W-1:0]  weight;
    logic signed [SCALE_W-1:0] scale;
    logic                      group_end;
    logic                      row_end;
  } igdd_item_t;

  // Zero acts as one, anything above K_MAX as K_MAX.
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > 32'(K_MAX)) begin
      r = LEN_W'(K_MAX);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/igdd_front.sv
// Front end: config registers, row/group counters, nibble select and end flags.
`timescale 1ns / 1ps
module igdd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [igdd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [igdd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             accept_i,
  input  logic [igdd_pkg::ACT_W-1:0]       act_i,
  input  logic [igdd_pkg::BYTE_W-1:0]      byte_i,
  input  logic [igdd_pkg::SCALE_W-1:0]     scale_i,
  output igdd_pkg::igdd_item_t             item_o
);
  import igdd_pkg::*;

  logic             scale_mode_q;
  logic [CFG_W-1:0] row_len_q;
  logic [CFG_W-1:0] grp_len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] gcnt_q, gcnt_d;

  logic [LEN_W-1:0]  rlen, glen;
  logic              row_end, group_end;
  logic [CODE_W-1:0] code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q <= SCALE_MODE_RST;
      row_len_q    <= ROW_LEN_RST;
      grp_len_q    <= GRP_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCALE_MODE: scale_mode_q <= cfg_data_i[0];
        REG_ROW_LENGTH: row_len_q    <= cfg_data_i;
        REG_GRP_LEN:    grp_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rlen      = eff_len(row_len_q);
    glen      = eff_len(grp_len_q);
    row_end   = ({1'b0, pos_q} + LEN_W'(1)) >= rlen;
    group_end = row_end || (scale_mode_q && (({1'b0, gcnt_q} + LEN_W'(1)) >= glen));
    // even element takes the low nibble
    code      = pos_q[0] ? byte_i[7:4] : byte_i[3:0];

    pos_d  = pos_q;
    gcnt_d = gcnt_q;
    if (accept_i) begin
      if (row_end) begin
        pos_d  = '0;
        gcnt_d = '0;
      end else begin
        pos_d  = pos_q + POS_W'(1);
        gcnt_d = group_end ? '0 : gcnt_q + POS_W'(1);
      end
    end

    // code - 8 in four bits is the code with its top bit flipped
    item_o.act       = act_i;
    item_o.weight    = {~code[3], code[2:0]};
    item_o.scale     = scale_i;
    item_o.group_end = group_end;
    item_o.row_end   = row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      gcnt_q <= '0;
    end else begin
      pos_q  <= pos_d;
      gcnt_q <= gcnt_d;
    end
  end

endmodule

FILE: rtl/igdd_fifo.sv
// Short queue of classified elements between front and back.
`timescale 1ns / 1ps
module igdd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  igdd_pkg::igdd_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output igdd_pkg::igdd_item_t item_o,
  output logic                 empty_o
);
  import igdd_pkg::*;

  igdd_item_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  always_comb begin
    full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
    empty_o = cnt_q == '0;
    item_o  = mem_q[rptr_q];
    cnt_d   = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/igdd_back.sv
// Back end: product, group accumulate, scale multiply, row sum, output register.
`timescale 1ns / 1ps
module igdd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  igdd_pkg::igdd_item_t            item_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [igdd_pkg::SUM_W-1:0]      out_data_o
);
  import igdd_pkg::*;

  logic en;

  // stage 1: activation x weight
  logic                      s1_valid_q, s1_ge_q, s1_re_q;
  logic signed [PROD_W-1:0]  s1_prod_q;
  logic signed [SCALE_W-1:0] s1_scale_q;
  // stage 2: finished group partial
  logic                      s2_valid_q, s2_re_q;
  logic signed [PART_W-1:0]  s2_part_q;
  logic signed [SCALE_W-1:0] s2_scale_q;
  // stage 3: scaled partial
  logic                      s3_valid_q, s3_re_q;
  logic signed [SUM_W-1:0]   s3_prod_q;

  logic signed [PART_W-1:0] partial_q, part_sum;
  logic [SUM_W-1:0]         row_sum_q, row_total;
  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_data_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  scaled;

  always_comb begin
    // whole pipeline moves together unless the output word is stuck
    en        = !out_valid_q || out_ready_i;
    pop_o     = en && !empty_i;
    prod      = PROD_W'(item_i.act) * PROD_W'(item_i.weight);
    part_sum  = partial_q + {{(PART_W-PROD_W){s1_prod_q[PROD_W-1]}}, s1_prod_q};
    // sign-extended 32x16 product
    scaled    = SUM_W'(s2_part_q) * SUM_W'(s2_scale_q);
    row_total = row_sum_q + s3_prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q  <= prod;
      s1_scale_q <= item_i.scale;
      s2_part_q  <= part_sum;
      s2_scale_q <= s1_scale_q;
      s3_prod_q  <= scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_ge_q     <= 1'b0;
      s1_re_q     <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_re_q     <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_re_q     <= 1'b0;
      partial_q   <= '0;
      row_sum_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (en) begin
      s1_valid_q <= pop_o;
      s1_ge_q    <= item_i.group_end;
      s1_re_q    <= item_i.row_end;
      s2_valid_q <= s1_valid_q && s1_ge_q;
      s2_re_q    <= s1_re_q;
      s3_valid_q <= s2_valid_q;
      s3_re_q    <= s2_re_q;
      if (s1_valid_q) begin
        partial_q <= s1_ge_q ? '0 : part_sum;
      end
      out_valid_q <= 1'b0;
      if (s3_valid_q) begin
        if (s3_re_q) begin
          row_sum_q   <= '0;
          out_data_q  <= row_total;
          out_valid_q <= 1'b1;
        end else begin
          row_sum_q <= row_total;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_re_has_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_re_q |-> s1_ge_q)
    else $error("row end without group end");

  a_stall_holds_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(partial_q) && $stable(row_sum_q))
    else $error("accumulators moved during stall");

  a_row_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s3_valid_q && s3_re_q |=> out_valid_q)
    else $error("row end did not load output");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !pop_o)
    else $error("queue popped while output stalled");

endmodule

FILE: rtl/int4_group_dequant_dot.sv
// Top level of the streaming int4 group-dequantized dot product.
`timescale 1ns / 1ps
// Streams one dot-product element per input word: activation, the packed
// weight byte holding its 4-bit code (low nibble on even positions), and the
// group scale. Weights are code - 8. Products accumulate per group; at each
// group end (after every configured group length of elements and at row end
// in group mode, or only at row end in per-row mode) the partial is scaled
// and added to the row sum, and at row end one 48-bit exact result word is
// sent. Sustained rate is one word per cycle while the output is not held:
// the front classifies and counts in the accepting cycle, and the back has
// three register stages (product, group add, 32x16 scale multiply) with the
// row add feeding the output register. The last word of a row passes the
// queue, the three stages and the output register before m_axis_tvalid
// rises. A four-word queue between front and back absorbs output stalls;
// when the output register is held, the back freezes and input keeps
// flowing until the queue fills. Write config only while idle.
module int4_group_dequant_dot (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [igdd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [igdd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] activation, [23:16] weight_byte, [39:24] group_scale
  input  logic [igdd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [47:0] dot_value
  output logic [igdd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import igdd_pkg::*;

  logic       accept, fifo_full, fifo_empty, pop;
  igdd_item_t front_item, back_item;

  assign s_axis_tready = !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // classify: nibble select, group/row end flags
  igdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .act_i       (s_axis_tdata[15:0]),
    .byte_i      (s_axis_tdata[23:16]),
    .scale_i     (s_axis_tdata[39:24]),
    .item_o      (front_item)
  );

  igdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .item_o  (back_item),
    .empty_o (fifo_empty)
  );

  // accumulate and scale
  igdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (back_item),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: tb/tb_int4_group_dequant_dot.sv
// Self-checking testbench for the int4 group-dequantized dot-product block.
`timescale 1ns / 1ps
module tb_int4_group_dequant_dot;
  import igdd_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  // Cycles to let the back pipeline and queue settle after the last result.
  localparam int SETTLE_CYCLES = 12;

  // Tracks the block's row/group state and holds the dot products still due.
  class dot_scoreboard;
    logic                      mode;
    logic [CFG_W-1:0]          row_len;
    logic [CFG_W-1:0]          group_len;
    int unsigned               pos;
    int unsigned               gcnt;
    logic signed [PART_W-1:0]  partial;
    logic signed [SUM_W-1:0]   rsum;
    logic signed [SUM_W-1:0]   expected_dots[$];
    int unsigned               errors;

    function new();
      mode      = SCALE_MODE_RST;
      row_len   = ROW_LEN_RST;
      group_len = GRP_LEN_RST;
      pos       = 0;
      gcnt      = 0;
      partial   = '0;
      rsum      = '0;
      errors    = 0;
    endfunction

    function void set_reg(igdd_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_SCALE_MODE: mode = v[0];
        REG_ROW_LENGTH: row_len = v;
        REG_GRP_LEN: group_len = v;
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past K_MAX as K_MAX
    function int unsigned clamp_len(logic [CFG_W-1:0] v);
      int unsigned r;
      r = 32'(v);
      if (r == 0) r = 1;
      else if (r > K_MAX) r = K_MAX;
      return r;
    endfunction

    function int unsigned pending();
      return expected_dots.size();
    endfunction

    // one accepted element: accumulate, close group/row as needed
    function void note_word(logic signed [ACT_W-1:0] act, logic [BYTE_W-1:0] wbyte,
                            logic signed [SCALE_W-1:0] scale);
      logic [CODE_W-1:0]        code;
      logic signed [CODE_W:0]   wgt;
      logic signed [PART_W-1:0] prod;
      logic signed [SUM_W-1:0]  scaled;
      bit                       row_end;
      bit                       group_end;
      code = pos[0] ? wbyte[7:4] : wbyte[3:0];
      wgt = $signed({1'b0, code}) - 5'sd8;
      row_end = (pos + 1) >= clamp_len(row_len);
      group_end = row_end || (mode && (gcnt + 1) >= clamp_len(group_len));
      prod = 32'(act) * 32'(wgt);
      partial = partial + prod;
      if (group_end) begin
        scaled = 48'(partial) * 48'(scale);
        rsum = rsum + scaled;
        partial = '0;
        gcnt = 0;
      end else begin
        gcnt++;
      end
      if (row_end) begin
        expected_dots.push_back(rsum);
        rsum = '0;
        pos = 0;
        gcnt = 0;
        partial = '0;
      end else begin
        pos++;
      end
    endfunction

    function void check_dot(logic signed [SUM_W-1:0] got);
      logic signed [SUM_W-1:0] want;
      if (expected_dots.size() == 0) begin
        $error("dot_value: no result expected, got %0d", got);
        errors++;
      end else begin
        want = expected_dots.pop_front();
        if (got !== want) begin
          $error("dot_value: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_SCALE_MODE;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [15:0] activation, [23:16] weight_byte, [39:24] group_scale
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [47:0] dot_value
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  dot_scoreboard sb = new();

  // idle percentages for sender and receiver, changed per stimulus pass
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  int4_group_dequant_dot dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random backpressure, changed on the falling edge only.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result words are checked as they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_dot(m_axis_tdata);
    end
  end

  // Hang detector: any accepted word on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // The write strobe drops before the task returns, keeping one assignment per signal per step.
  task automatic write_reg(input igdd_reg_e idx, input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [CFG_W-1:0] rlen,
                            input logic [CFG_W-1:0] glen);
    write_reg(REG_SCALE_MODE, {{(CFG_W-1){1'b0}}, mode});
    write_reg(REG_ROW_LENGTH, rlen);
    write_reg(REG_GRP_LEN, glen);
  endtask

  // Drive one element word; returns at the falling edge after it is taken.
  // tvalid stays high on return so back-to-back words need no re-raise.
  task automatic send_item(input logic signed [ACT_W-1:0] act,
                           input logic [BYTE_W-1:0] wbyte,
                           input logic signed [SCALE_W-1:0] scale);
    // now and then hold off until every due row has come out
    if ($urandom_range(0, 149) == 0) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while (sb.pending() != 0) @(negedge clk_i);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {scale, wbyte, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(act, wbyte, scale);
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every due row, then let the pipe settle so a
  // partial row in flight is fully absorbed before any register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic             mode;
    logic [CFG_W-1:0] rlen;
    logic [CFG_W-1:0] glen;
    int               pick;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // reset registers (row 4096, group 32): start a row, then shorten it
    // mid-row; the next word reaches the new length and closes the row
    send_item(-16'sd32768, 8'h00, 16'sd32767);
    send_item(16'sd32767, 8'hFF, -16'sd32768);
    send_item(-16'sd1, 8'h0F, 16'sd1);
    drain();
    write_reg(REG_ROW_LENGTH, 13'd4);
    send_item(16'sd12345, 8'hF0, -16'sd32768);
    drain();

    // row length zero acts as one: every word is a row, always low nibble
    write_reg(REG_ROW_LENGTH, 13'd0);
    send_item(-16'sd32768, 8'h00, -16'sd32768);
    send_item(-16'sd32768, 8'hFF, 16'sd32767);
    send_item(16'sd32767, 8'h08, 16'sd100);
    send_item(16'sd32767, 8'hF0, 16'sd32767);
    drain();

    // per-row scale: only the row-end scale matters
    set_config(1'b0, 13'd6, 13'd0);
    send_item(16'sd32767, 8'h0F, 16'sd5);
    send_item(-16'sd32768, 8'h0F, -16'sd7);
    send_item(16'sd1000, 8'hA5, 16'sd32767);
    send_item(-16'sd1000, 8'h5A, 16'sd0);
    send_item(16'sd32767, 8'h77, -16'sd1);
    send_item(-16'sd32768, 8'h88, -16'sd32768);
    drain();

    // group size zero acts as one: every word closes a group
    set_config(1'b1, 13'd6, 13'd0);
    send_item(16'sd32767, 8'hF0, 16'sd32767);
    send_item(-16'sd32768, 8'h0F, -16'sd32768);
    send_item(16'sd2, 8'h3C, -16'sd3);
    send_item(-16'sd2, 8'hC3, 16'sd3);
    send_item(16'sd32767, 8'hFF, -16'sd32768);
    send_item(-16'sd32768, 8'h00, 16'sd32767);
    drain();

    // group size past K_MAX: the group only closes at row end
    set_config(1'b1, 13'd5, 13'd8191);
    send_item(16'sd300, 8'h12, 16'sd9);
    send_item(-16'sd300, 8'h34, 16'sd8);
    send_item(16'sd32767, 8'h56, 16'sd7);
    send_item(-16'sd32768, 8'h78, 16'sd6);
    send_item(16'sd4321, 8'h9A, -16'sd32768);
    drain();

    // --- random: three idle profiles, many short configs in each ---
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin send_idle_pct = 37; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 10; ph++) begin
        mode = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) rlen = 13'd0;
        else if (pick == 1) rlen = CFG_W'($urandom_range(41, 200));
        else if (pick < 4) rlen = CFG_W'($urandom_range(1, 8));
        else rlen = CFG_W'($urandom_range(1, 40));
        pick = $urandom_range(0, 9);
        if (pick == 0) glen = 13'd0;
        else if (pick == 1) glen = CFG_W'($urandom_range(K_MAX + 1, 8191));
        else if (pick < 4) glen = CFG_W'($urandom_range(17, 64));
        else glen = CFG_W'($urandom_range(1, 16));
        // phase boundaries fall mid-row too, so this also exercises
        // register changes against a partly summed row
        set_config(mode, rlen, glen);
        for (int i = 0; i < 50; i++) begin
          send_item(16'($urandom), 8'($urandom), 16'($urandom));
        end
        drain();
      end
    end

    // row length register past K_MAX: a long row runs without closing,
    // then a row length of one closes it on the next word
    set_config(1'b1, 13'd8191, 13'd129);
    for (int i = 0; i < 300; i++) begin
      send_item(16'($urandom), 8'($urandom), 16'($urandom));
    end
    drain();
    write_reg(REG_ROW_LENGTH, 13'd1);
    send_item(16'($urandom), 8'($urandom), 16'($urandom));
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/igdd_pkg.sv
rtl/igdd_front.sv
rtl/igdd_fifo.sv
rtl/igdd_back.sv
rtl/int4_group_dequant_dot.sv
tb/tb_int4_group_dequant_dot.sv
